>>> src/iebm_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master package
// Shared codes, constants and the result word type of the byte master.
// ----------------------------------------------------------------------------
`default_nettype none

package iebm_pkg;

  // Command codes carried by the input word.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes reported with done.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
  localparam logic [1:0] ST_BUS_FAULT = 2'd2;
  localparam logic [1:0] ST_NO_ACK    = 2'd3;

  // Bus segments; the phase is the segment followed by a two-bit quarter.
  localparam logic [3:0] SEG_IDLE      = 4'd0;
  localparam logic [3:0] SEG_START     = 4'd1;
  localparam logic [3:0] SEG_DEV       = 4'd2;
  localparam logic [3:0] SEG_ACK_DEV   = 4'd3;
  localparam logic [3:0] SEG_ADDR      = 4'd4;
  localparam logic [3:0] SEG_ACK_ADDR  = 4'd5;
  localparam logic [3:0] SEG_DATA      = 4'd6;
  localparam logic [3:0] SEG_ACK_DATA  = 4'd7;
  localparam logic [3:0] SEG_RESTART   = 4'd8;
  localparam logic [3:0] SEG_DEVR      = 4'd9;
  localparam logic [3:0] SEG_ACK_DEVR  = 4'd10;
  localparam logic [3:0] SEG_RECV      = 4'd11;
  localparam logic [3:0] SEG_NOACK     = 4'd12;
  localparam logic [3:0] SEG_STOP      = 4'd13;
  localparam logic [3:0] SEG_STOP_FAIL = 4'd14;

  // Quarters of one bit cell.
  localparam logic [1:0] Q_0 = 2'd0;
  localparam logic [1:0] Q_1 = 2'd1;
  localparam logic [1:0] Q_2 = 2'd2;

  localparam logic [7:0] DEV_ADDR_RESET = 8'd160;
  localparam logic [7:0] READ_BIT       = 8'h01;
  localparam logic [4:0] BITS_PER_BYTE  = 5'd8;

  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } result_t;

endpackage

`default_nettype wire

>>> src/iebm_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master channel interfaces
// Valid/ready channels for tick input, tick result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface iebm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] mem_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, cmd, mem_addr, write_data, sda_in, input ready);
  modport sink   (input valid, cmd, mem_addr, write_data, sda_in, output ready);
endinterface

interface iebm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;
  logic       cmd_rejected;

  modport source (output valid, scl_out, sda_release, busy_res, done_res, status,
                  read_data, cmd_rejected, input ready);
  modport sink   (input valid, scl_out, sda_release, busy_res, done_res, status,
                  read_data, cmd_rejected, output ready);
endinterface

interface iebm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_address;

  modport source (output valid, device_address, input ready);
  modport sink   (input valid, device_address, output ready);
endinterface

`default_nettype wire

>>> src/i2c_eeprom_byte_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master core
// Bit-level I2C master for single-byte write and random read of a small
// serial EEPROM, advanced one quarter-bit tick per input word.
// ----------------------------------------------------------------------------
// Usage: every word on in_ch is one bus tick from an external prescaler. It
// carries the sampled SDA level and, while the master is idle, an optional
// write or random-read command with word address and data. Each accepted
// word yields exactly one result word on out_ch with the SCL level, the SDA
// release bit, busy, done, status, read data and a command-rejected flag.
// The device address byte is written on cfg_ch, which is always ready; it
// must only change while no transaction is in progress.
// The result of a word is registered. Throughput is one word per cycle while
// in_ch.ready is high; the whole tick update is one pass of logic from the
// bus state registers. A two-entry output stage (result register plus skid
// register) lets the master take a word while a result is still waiting;
// in_ch.ready drops only when both entries hold results that the receiver
// has not taken.
// Reset (rst_n low, synchronous) returns the bus state to idle with SCL and
// SDA released, empties the output stage and sets the device address to
// 0xA0.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_master_core
  import iebm_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  iebm_in_if.sink       in_ch,
  iebm_out_if.source    out_ch,
  iebm_cfg_if.sink      cfg_ch
);

  // Bus state.
  logic [5:0] phase_r,      phase_nxt;
  logic [3:0] bit_count_r,  bit_count_nxt;
  logic [7:0] shift_r,      shift_nxt;
  logic       is_read_r,    is_read_nxt;
  logic [7:0] addr_latch_r, addr_latch_nxt;
  logic [7:0] data_latch_r, data_latch_nxt;
  logic       scl_r,        scl_nxt;
  logic       sda_r,        sda_nxt;
  logic [7:0] dev_addr_r;

  // Output stage.
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  result_t res;

  logic       in_acc;
  logic [3:0] seg;
  logic [1:0] q;
  logic       is_cmd;
  logic [4:0] bc_inc;
  logic       byte_end;
  logic       done;
  logic [1:0] status;
  logic [7:0] rdata;
  logic       rej;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign seg      = phase_r[5:2];
  assign q        = phase_r[1:0];
  assign is_cmd   = (in_ch.cmd == CMD_WRITE) || (in_ch.cmd == CMD_READ);
  assign bc_inc   = {1'b0, bit_count_r} + 5'd1;
  assign byte_end = (bc_inc >= BITS_PER_BYTE);

  // One tick of the bus sequencer.
  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    is_read_nxt    = is_read_r;
    addr_latch_nxt = addr_latch_r;
    data_latch_nxt = data_latch_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    done           = 1'b0;
    status         = ST_OK;
    rdata          = 8'd0;
    rej            = 1'b0;

    if ((seg == SEG_IDLE) || (seg > SEG_STOP_FAIL)) begin
      phase_nxt = 6'd0;
      if (is_cmd) begin
        // The command tick already drives the first quarter of the start.
        addr_latch_nxt = in_ch.mem_addr;
        data_latch_nxt = in_ch.write_data;
        is_read_nxt    = (in_ch.cmd == CMD_READ);
        scl_nxt        = 1'b1;
        sda_nxt        = 1'b1;
        phase_nxt      = {SEG_START, Q_1};
      end
    end else begin
      rej = is_cmd;
      case (seg)
        SEG_START, SEG_RESTART: begin
          if (q == Q_0) begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_1) begin
            // Another master or a stuck device holds SDA low.
            if ((seg == SEG_START) && !in_ch.sda_in) begin
              done      = 1'b1;
              status    = ST_BUS_BUSY;
              phase_nxt = 6'd0;
            end else begin
              sda_nxt   = 1'b0;
              phase_nxt = phase_r + 6'd1;
            end
          end else begin
            // SDA did not follow our pull-down: the line is broken.
            if ((seg == SEG_START) && in_ch.sda_in) begin
              done      = 1'b1;
              status    = ST_BUS_FAULT;
              phase_nxt = 6'd0;
            end else begin
              sda_nxt       = 1'b0;
              bit_count_nxt = 4'd0;
              if (seg == SEG_START) begin
                phase_nxt = {SEG_DEV, Q_0};
                shift_nxt = dev_addr_r;
              end else begin
                phase_nxt = {SEG_DEVR, Q_0};
                shift_nxt = dev_addr_r | READ_BIT;
              end
            end
          end
        end
        SEG_DEV, SEG_ADDR, SEG_DATA, SEG_DEVR: begin
          if (q == Q_0) begin
            scl_nxt   = 1'b0;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_1) begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_2) begin
            scl_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else if (byte_end) begin
            bit_count_nxt = 4'd0;
            phase_nxt     = {seg + 4'd1, Q_0};
          end else begin
            bit_count_nxt = bc_inc[3:0];
            phase_nxt     = {seg, Q_0};
          end
        end
        SEG_ACK_DEV, SEG_ACK_ADDR, SEG_ACK_DATA, SEG_ACK_DEVR, SEG_NOACK: begin
          if (q == Q_0) begin
            scl_nxt   = 1'b0;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_1) begin
            sda_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_2) begin
            scl_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else if (seg == SEG_ACK_DEV) begin
            // Only the device byte acknowledge is checked.
            if (in_ch.sda_in) begin
              phase_nxt = {SEG_STOP_FAIL, Q_0};
            end else begin
              phase_nxt     = {SEG_ADDR, Q_0};
              shift_nxt     = addr_latch_r;
              bit_count_nxt = 4'd0;
            end
          end else if (seg == SEG_ACK_ADDR) begin
            if (is_read_r) begin
              phase_nxt = {SEG_RESTART, Q_0};
            end else begin
              phase_nxt     = {SEG_DATA, Q_0};
              shift_nxt     = data_latch_r;
              bit_count_nxt = 4'd0;
            end
          end else if ((seg == SEG_ACK_DATA) || (seg == SEG_NOACK)) begin
            phase_nxt = {SEG_STOP, Q_0};
          end else begin
            phase_nxt     = {SEG_RECV, Q_0};
            shift_nxt     = 8'd0;
            bit_count_nxt = 4'd0;
          end
        end
        SEG_RECV: begin
          if (q == Q_0) begin
            scl_nxt   = 1'b0;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_1) begin
            sda_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_2) begin
            scl_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else begin
            shift_nxt = {shift_r[6:0], in_ch.sda_in};
            if (byte_end) begin
              bit_count_nxt = 4'd0;
              phase_nxt     = {SEG_NOACK, Q_0};
            end else begin
              bit_count_nxt = bc_inc[3:0];
              phase_nxt     = {SEG_RECV, Q_0};
            end
          end
        end
        default: begin
          // Stop condition, after success or after a missing device ack.
          if (q == Q_0) begin
            scl_nxt   = 1'b0;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_1) begin
            sda_nxt   = 1'b0;
            phase_nxt = phase_r + 6'd1;
          end else if (q == Q_2) begin
            scl_nxt   = 1'b1;
            phase_nxt = phase_r + 6'd1;
          end else begin
            sda_nxt   = 1'b1;
            done      = 1'b1;
            phase_nxt = 6'd0;
            if (seg == SEG_STOP_FAIL) begin
              status = ST_NO_ACK;
            end else if (is_read_r) begin
              rdata = shift_r;
            end
          end
        end
      endcase
      if (done) begin
        bit_count_nxt = 4'd0;
      end
    end
  end

  always_comb begin
    res.scl_out      = scl_nxt;
    res.sda_release  = sda_nxt;
    res.busy_res     = (phase_nxt != 6'd0);
    res.done_res     = done;
    res.status       = status;
    res.read_data    = rdata;
    res.cmd_rejected = rej;
  end

  // Bus state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 6'd0;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      is_read_r    <= 1'b0;
      addr_latch_r <= 8'd0;
      data_latch_r <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      dev_addr_r   <= DEV_ADDR_RESET;
    end else begin
      if (in_acc) begin
        phase_r      <= phase_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_r      <= shift_nxt;
        is_read_r    <= is_read_nxt;
        addr_latch_r <= addr_latch_nxt;
        data_latch_r <= data_latch_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
      end
      if (cfg_ch.valid) begin
        dev_addr_r <= cfg_ch.device_address;
      end
    end
  end

  // Output stage: a new result goes to the skid register only when the
  // result register is full and not being taken in this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_valid_r && out_ch.ready) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_ch.ready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_valid_r && out_ch.ready && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_out      = out_r.scl_out;
  assign out_ch.sda_release  = out_r.sda_release;
  assign out_ch.busy_res     = out_r.busy_res;
  assign out_ch.done_res     = out_r.done_res;
  assign out_ch.status       = out_r.status;
  assign out_ch.read_data    = out_r.read_data;
  assign out_ch.cmd_rejected = out_r.cmd_rejected;

endmodule

`default_nettype wire
